>>> hw/rtl/totp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types and constants for the TOTP code generator.
// ----------------------------------------------------------------------------
package totp_pkg;

    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KEYLEN = 3'd4,
        REG_STEP   = 3'd5,
        REG_DIGITS = 3'd6
    } cfg_idx_t;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;

    // Start/done handshake between sequencer and the SHA-1 round unit.
    typedef struct packed {
        logic         start;
        logic [159:0] chain;
        logic [511:0] block;
    } sha_req_t;

    typedef struct packed {
        logic         done;
        logic [159:0] digest;
    } sha_rsp_t;

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        if (rnd < 7'd20)      return 32'h5A827999;
        else if (rnd < 7'd40) return 32'h6ED9EBA1;
        else if (rnd < 7'd60) return 32'h8F1BBCDC;
        else                  return 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        if (rnd < 7'd20)      return (b & c) | (~b & d);
        else if (rnd < 7'd40) return b ^ c ^ d;
        else if (rnd < 7'd60) return (b & c) | (b & d) | (c & d);
        else                  return b ^ c ^ d;
    endfunction

endpackage : totp_pkg
`default_nettype wire

>>> hw/rtl/totp_sha1_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// totp_sha1_core
// One SHA-1 compression, one round per cycle over a 16-word schedule window.
// ----------------------------------------------------------------------------
module totp_sha1_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire totp_pkg::sha_req_t req,
    output totp_pkg::sha_rsp_t      rsp
);
    import totp_pkg::*;

    logic         run_reg;
    logic [6:0]   rnd_reg;
    logic [511:0] w_reg;
    logic [159:0] h_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic         done_reg;

    logic [31:0] w0, wnew, t;

    assign w0   = w_reg[511:480];
    assign wnew = {w_reg[511-2*32 -: 32] ^ w_reg[511-8*32 -: 32] ^
                   w_reg[511-13*32 -: 32] ^ w_reg[511 -: 32]};
    assign t    = {a_reg[26:0], a_reg[31:27]} + sha1_f(rnd_reg, b_reg, c_reg, d_reg)
                  + e_reg + sha1_k(rnd_reg) + w0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
                w_reg   <= req.block;
                h_reg   <= req.chain;
                {a_reg, b_reg, c_reg, d_reg, e_reg} <= req.chain;
            end
            else if (run_reg)
            begin
                // window shifts by one word; new word = rotl1 of the xor taps
                w_reg <= {w_reg[479:0], wnew[30:0], wnew[31]};
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                b_reg <= a_reg;
                a_reg <= t;
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.digest = {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg,
                         h_reg[95:64] + c_reg, h_reg[63:32] + d_reg, h_reg[31:0] + e_reg};

endmodule : totp_sha1_core
`default_nettype wire

>>> hw/rtl/totp_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// totp_divider
// Restoring divider, one quotient bit per cycle; 64-bit dividend.
// ----------------------------------------------------------------------------
module totp_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient,
    output logic [31:0]      remainder
);
    logic        run_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {r_reg[31:0], q_reg[63]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                q_reg   <= dividend;
                r_reg   <= '0;
                d_reg   <= divisor;
            end
            else if (run_reg)
            begin
                r_reg   <= fits ? trial - {1'b0, d_reg} : trial;
                q_reg   <= {q_reg[62:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // divide by zero gives all ones naturally
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[31:0];

endmodule : totp_divider
`default_nettype wire

>>> hw/rtl/totp_code_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// totp_code_generator
// HMAC-SHA1 TOTP: time / step, HMAC of the counter, truncation, mod 10^d (d clamped to 6..8).
// ----------------------------------------------------------------------------
// Sequence: time / step on the shared divider, four SHA-1 compressions,
// mod 10^d on the same divider, then the code register.
// A new start is taken only in idle; busy drops in the cycle after the strobe.
// The code strobe lasts one cycle and cannot be stalled.
// Reset: registers to key 0, key length 20, step 30, 6 digits; sequencer idle.
module totp_code_generator #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] unix_time,
    output logic             code_valid,
    output logic [26:0]      code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import totp_pkg::*;

    localparam int KeyCap = (MAX_KEY_BYTES < 32) ? MAX_KEY_BYTES : 32;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_IN1, S_IN2, S_OUT1, S_OUT2, S_MOD, S_DONE
    } state_t;

    state_t       state_reg;
    logic [255:0] key_reg;
    logic [5:0]   keylen_reg;
    logic [31:0]  step_reg;
    logic [3:0]   digits_reg;
    logic [159:0] ihash_reg;
    logic         code_valid_reg;
    logic [26:0]  code_reg;

    sha_req_t     req;
    sha_rsp_t     rsp;
    logic         div_start, div_done;
    logic [63:0]  div_dividend, div_q;
    logic [31:0]  div_divisor, div_r;

    logic [511:0] key_blk;
    logic [5:0]   eff_len;
    logic [26:0]  modulus;
    logic [3:0]   off;
    logic [159:0] dg;
    logic [31:0]  trunc;

    always_comb
    begin
        eff_len = (keylen_reg > 6'(KeyCap)) ? 6'(KeyCap) : keylen_reg;
        key_blk = '0;
        for (int i = 0; i < 32; i++)
            if (6'(i) < eff_len)
                key_blk[511-8*i -: 8] = key_reg[255-8*i -: 8];
    end

    always_comb
    begin
        if (digits_reg <= 4'd6)      modulus = 27'd1000000;
        else if (digits_reg == 4'd7) modulus = 27'd10000000;
        else                         modulus = 27'd100000000;
    end

    assign dg    = rsp.digest;
    assign off   = dg[3:0];
    assign trunc = dg[159 - 8*off -: 32] & 32'h7FFF_FFFF;

    // second block of each hash chains straight off the digest of the first
    always_comb
    begin
        req.start = 1'b0;
        req.chain = SHA1_IV;
        req.block = key_blk ^ {64{IPAD}};
        case (state_reg)
            S_DIV:  if (div_done) req.start = 1'b1;
            S_IN1:
            begin
                req.chain = rsp.digest;
                req.block = {div_q, 8'h80, 376'd0, 64'd576};
                req.start = rsp.done;
            end
            S_IN2:
            begin
                req.block = key_blk ^ {64{OPAD}};
                req.start = rsp.done;
            end
            S_OUT1:
            begin
                req.chain = rsp.digest;
                req.block = {ihash_reg, 8'h80, 280'd0, 64'd672};
                req.start = rsp.done;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = unix_time;
        div_divisor  = step_reg;
        case (state_reg)
            S_IDLE: div_start = start;
            S_OUT2:
            begin
                div_start    = rsp.done;
                div_dividend = {32'd0, trunc};
                div_divisor  = {5'd0, modulus};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_reg        <= '0;
            keylen_reg     <= 6'd20;
            step_reg       <= 32'd30;
            digits_reg     <= 4'd6;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            code_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_KEY0:   key_reg[255:192] <= cfg_data;
                    REG_KEY1:   key_reg[191:128] <= cfg_data;
                    REG_KEY2:   key_reg[127:64]  <= cfg_data;
                    REG_KEY3:   key_reg[63:0]    <= cfg_data;
                    REG_KEYLEN: keylen_reg       <= cfg_data[5:0];
                    REG_STEP:   step_reg         <= cfg_data[31:0];
                    REG_DIGITS: digits_reg       <= cfg_data[3:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: if (start) state_reg <= S_DIV;
                S_DIV:  if (div_done) state_reg <= S_IN1;
                S_IN1:  if (rsp.done) state_reg <= S_IN2;
                S_IN2:
                    if (rsp.done)
                    begin
                        ihash_reg <= rsp.digest;
                        state_reg <= S_OUT1;
                    end
                S_OUT1: if (rsp.done) state_reg <= S_OUT2;
                S_OUT2: if (rsp.done) state_reg <= S_MOD;
                S_MOD:
                    if (div_done)
                    begin
                        code_reg       <= div_r[26:0];
                        code_valid_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    totp_sha1_core u_sha (
        .clk (clk),
        .rst_n (rst_n),
        .req (req),
        .rsp (rsp)
    );

    totp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign code_valid = code_valid_reg;
    assign code       = code_reg;

endmodule : totp_code_generator
`default_nettype wire
